// ----- design/assert_macros.svh -----
// Assertion macros used by the run-length compressor RTL.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, outside reset.
`define RLCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define RLCC_ASSERT_NEXT(lbl, pre, post, msg) \
  `RLCC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ----- design/rlcc_pkg.sv -----
// Shared types and constants of the run-length compressor.
// Depends on nothing; imported by rlcc_run, rlcc_emit and the top level.
package rlcc_pkg;

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;
  // Holds a digit count of up to fifteen, the widest counter supported.
  localparam int NDIG_W  = 4;

  localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

  // One run to flush: its byte and how many count digits follow it.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] run_byte;
    logic [NDIG_W-1:0] ndig;
  } flush_hdr_t;

  // Everything one input word causes: an old run, then the current one.
  typedef struct packed {
    logic       valid;
    logic       str_last;
    flush_hdr_t a;
    flush_hdr_t b;
  } job_t;

endpackage

// ----- design/run_length_char_compressor_unit.sv -----
// Top level of the run-length compressor with decimal run counts.
// Depends on rlcc_pkg, rlcc_run and rlcc_emit.
//
// Feed one byte per word on in_char, with in_last high on the final byte of a
// string. Each run comes out as its byte followed, when longer than one, by its
// length in ASCII decimal, most significant digit first; a run that reaches
// all nines in COUNT_DIGITS digits is closed at once and an equal byte starts a
// fresh run. out_batch_last marks the last byte caused by one input word and
// out_string_end the last byte of the string. A word that only extends a run
// gives nothing. A word that closes runs holds the input while the single-job
// emitter walks out the bytes it yields (one for each run byte plus one for
// each count digit, at most COUNT_DIGITS+2), one per cycle while out_stall is
// low; the next word is taken in the cycle its last byte enters the output
// register. The first byte of a word is loaded into the job register as the
// word is taken and passes from there into the output register.
module run_length_char_compressor_unit #(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rlcc_pkg::BYTE_W-1:0]   in_char,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlcc_pkg::BYTE_W-1:0]   out_char,
  output logic                          out_batch_last,
  output logic                          out_string_end
);
  import rlcc_pkg::*;

  localparam int CW = COUNT_DIGITS * DIGIT_W;

  job_t          job;
  logic [CW-1:0] dig_a, dig_b;
  logic          job_free;
  logic          take;

  // Accept a word only when the emitter can take whatever job it builds.
  assign in_stall = !job_free;
  assign take     = in_valid && job_free;

  rlcc_run #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_run (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_char(in_char),
    .in_last(in_last),
    .take   (take),
    .job    (job),
    .dig_a  (dig_a),
    .dig_b  (dig_b)
  );

  rlcc_emit #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .job_i         (job),
    .dig_a_i       (dig_a),
    .dig_b_i       (dig_b),
    .job_free      (job_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_batch_last(out_batch_last),
    .out_string_end(out_string_end)
  );

endmodule

// ----- design/rlcc_run.sv -----
// Run tracker: holds the open run's byte and BCD length, builds the flush job.
// Depends on rlcc_pkg.
module rlcc_run #(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [rlcc_pkg::BYTE_W-1:0]             in_char,
  input  logic                                    in_last,
  input  logic                                    take,
  output rlcc_pkg::job_t                          job,
  output logic [COUNT_DIGITS*rlcc_pkg::DIGIT_W-1:0] dig_a,
  output logic [COUNT_DIGITS*rlcc_pkg::DIGIT_W-1:0] dig_b
);
  import rlcc_pkg::*;

  localparam int CW = COUNT_DIGITS * DIGIT_W;

  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [CW-1:0]     digits_r, digits_nxt;
  logic              open_r, open_nxt;
  logic              change, start, sat;

  function automatic logic [CW-1:0] bcd_inc(input logic [CW-1:0] d);
    logic [CW-1:0] r;
    logic          carry;
    r     = d;
    carry = 1'b1;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if (carry) begin
        if (d[k*DIGIT_W +: DIGIT_W] == DIGIT_NINE) begin
          r[k*DIGIT_W +: DIGIT_W] = '0;
        end else begin
          r[k*DIGIT_W +: DIGIT_W] = d[k*DIGIT_W +: DIGIT_W] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic all_nines(input logic [CW-1:0] d);
    logic r;
    r = 1'b1;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if (d[k*DIGIT_W +: DIGIT_W] != DIGIT_NINE) r = 1'b0;
    end
    return r;
  endfunction

  // Digits to print: none for a run of one, else down from the top nonzero digit.
  function automatic logic [NDIG_W-1:0] digit_count(input logic [CW-1:0] d);
    logic [NDIG_W-1:0] top;
    top = '0;
    for (int k = 1; k < COUNT_DIGITS; k++) begin
      if (d[k*DIGIT_W +: DIGIT_W] != '0) top = NDIG_W'(k);
    end
    return (top != '0 || d[DIGIT_W-1:0] > DIGIT_W'(1)) ? top + 1'b1 : '0;
  endfunction

  always_comb begin
    change     = open_r && (in_char != byte_r);
    start      = !open_r || change;
    byte_nxt   = start ? in_char : byte_r;
    digits_nxt = start ? CW'(1) : bcd_inc(digits_r);
    sat        = all_nines(digits_nxt);
    open_nxt   = !(sat || in_last);

    job.a.valid    = change;
    job.a.run_byte = byte_r;
    job.a.ndig     = digit_count(digits_r);
    job.b.valid    = sat || in_last;
    job.b.run_byte = byte_nxt;
    job.b.ndig     = digit_count(digits_nxt);
    job.str_last   = in_last;
    job.valid      = change || sat || in_last;
  end

  assign dig_a = digits_r;
  assign dig_b = digits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r   <= '0;
      digits_r <= '0;
      open_r   <= 1'b0;
    end else if (take) begin
      byte_r   <= byte_nxt;
      digits_r <= digits_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

// ----- design/rlcc_emit.sv -----
// Emitter: holds one flush job and walks it out, one byte a cycle while out_stall
// is low, into the output register. Depends on rlcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlcc_emit #(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      take,
  input  rlcc_pkg::job_t                            job_i,
  input  logic [COUNT_DIGITS*rlcc_pkg::DIGIT_W-1:0] dig_a_i,
  input  logic [COUNT_DIGITS*rlcc_pkg::DIGIT_W-1:0] dig_b_i,
  output logic                                      job_free,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [rlcc_pkg::BYTE_W-1:0]               out_char,
  output logic                                      out_batch_last,
  output logic                                      out_string_end
);
  import rlcc_pkg::*;

  localparam int CW    = COUNT_DIGITS * DIGIT_W;
  localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  job_t              job_r;
  logic [CW-1:0]     dig_a_r, dig_b_r;
  logic              phase_r;
  logic [NDIG_W-1:0] pos_r;
  logic              out_valid_r, out_batch_last_r, out_string_end_r;
  logic [BYTE_W-1:0] out_char_r;

  flush_hdr_t        hdr;
  logic [CW-1:0]     dig;
  logic [NDIG_W-1:0] idx_full;
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] cur_byte;
  logic              flush_end, job_end, out_load;

  always_comb begin
    hdr       = phase_r ? job_r.b : job_r.a;
    dig       = phase_r ? dig_b_r : dig_a_r;
    idx_full  = hdr.ndig - pos_r;
    idx       = idx_full[IDX_W-1:0];
    cur_byte  = (pos_r == '0) ? hdr.run_byte
              : ASCII_ZERO + BYTE_W'(dig[idx*DIGIT_W +: DIGIT_W]);
    flush_end = (pos_r == hdr.ndig);
    job_end   = flush_end && (phase_r || !job_r.b.valid);
    out_load  = job_r.valid && (!out_valid_r || !out_stall);
    job_free  = !job_r.valid || (out_load && job_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r.valid <= 1'b0;
      phase_r     <= 1'b0;
      pos_r       <= '0;
    end else if (take && job_i.valid) begin
      // A new job replaces the one that retires in the same cycle.
      job_r   <= job_i;
      dig_a_r <= dig_a_i;
      dig_b_r <= dig_b_i;
      phase_r <= !job_i.a.valid;
      pos_r   <= '0;
    end else if (out_load) begin
      if (job_end) begin
        job_r.valid <= 1'b0;
      end else if (flush_end) begin
        phase_r <= 1'b1;
        pos_r   <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r       <= cur_byte;
      out_batch_last_r <= job_end;
      out_string_end_r <= job_end && job_r.str_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_batch_last = out_batch_last_r;
  assign out_string_end = out_string_end_r;

  `RLCC_ASSERT(a_end_is_batch_end, out_valid_r && out_string_end_r |-> out_batch_last_r,
               "string end without batch end")
  `RLCC_ASSERT(a_phase_has_run, job_r.valid |-> (phase_r ? job_r.b.valid : job_r.a.valid),
               "emitter walks a run that is not in the job")
  `RLCC_ASSERT(a_pos_in_range, job_r.valid |-> pos_r <= hdr.ndig,
               "emitter position past the last digit")
  `RLCC_ASSERT_NEXT(a_retire_frees, job_r.valid && out_load && job_end && !take,
                    !job_r.valid, "finished job still held")

endmodule
